>>> hw/rtl/fbrf_pkg.sv
// Shared constants and types for the fill byte run finder.
package fbrf_pkg;

    // Width of the internal byte address counter.
    localparam int ADDR_BITS = 32;

    // Widths of the run report fields.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;
    localparam int POS_W  = 32;

    // The two pad byte values that form runs.
    localparam logic [BYTE_W-1:0] PAD_LOW  = 8'h00;
    localparam logic [BYTE_W-1:0] PAD_HIGH = 8'hFF;

    // Saturation value of the run length.
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Reset value of the minimum reported length.
    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 32'd1;

    // Output queue depth and its occupancy counter width.
    localparam int Q_DEPTH = 3;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Width of the per-byte report count (zero, one or two reports).
    localparam int PCNT_W = 2;

    // One run report as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0] fill_value;
        logic [POS_W-1:0]  run_start;
        logic [LEN_W-1:0]  run_length;
        logic              last_report;
    } result_t;

    // Reports raised by one accepted byte, in delivery order.
    typedef struct packed {
        logic [PCNT_W-1:0] count;
        result_t           first;
        result_t           second;
    } push_t;

endpackage

>>> hw/rtl/fbrf_core.sv
// Run tracker: follows pad byte runs and raises up to two reports per byte.
module fbrf_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic [fbrf_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                end_of_stream,
    input  logic [fbrf_pkg::LEN_W-1:0]          min_run_len,
    output fbrf_pkg::push_t                     push
);

    // Run state.
    logic [fbrf_pkg::BYTE_W-1:0]    prior_reg, prior_next;
    logic                           in_run_reg, in_run_next;
    logic [fbrf_pkg::ADDR_BITS-1:0] start_reg, start_next;
    logic [fbrf_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [fbrf_pkg::ADDR_BITS-1:0] addr_reg, addr_next;

    // Intermediate values after the byte itself, before the end-of-stream flush.
    logic                           is_pad;
    logic                           extend;
    logic                           emit_a;
    logic                           emit_b;
    logic                           run_open;
    logic [fbrf_pkg::ADDR_BITS-1:0] run_start;
    logic [fbrf_pkg::LEN_W-1:0]     run_len;
    fbrf_pkg::result_t              rec_a;
    fbrf_pkg::result_t              rec_b;

    // Classify the byte and work out the run that is open after it.
    always_comb
    begin
        is_pad = (data_byte == fbrf_pkg::PAD_LOW) || (data_byte == fbrf_pkg::PAD_HIGH);
        extend = is_pad && in_run_reg && (prior_reg == data_byte);

        // Any byte that does not extend the open run closes it.
        emit_a = !extend && in_run_reg && (len_reg >= min_run_len);

        if (extend)
        begin
            run_open  = 1'b1;
            run_start = start_reg;
            run_len   = (len_reg == fbrf_pkg::LEN_MAX) ? len_reg : len_reg + 1'b1;
        end
        else if (is_pad)
        begin
            run_open  = 1'b1;
            run_start = addr_reg;
            run_len   = fbrf_pkg::LEN_W'(1);
        end
        else
        begin
            run_open  = 1'b0;
            run_start = '0;
            run_len   = '0;
        end

        // The end-of-stream mark flushes whatever run is still open.
        emit_b = end_of_stream && run_open && (run_len >= min_run_len);
    end

    // Build the report records and order them.
    always_comb
    begin
        rec_a.fill_value  = prior_reg;
        rec_a.run_start   = fbrf_pkg::POS_W'(start_reg);
        rec_a.run_length  = len_reg;
        rec_a.last_report = !emit_b;

        rec_b.fill_value  = data_byte;
        rec_b.run_start   = fbrf_pkg::POS_W'(run_start);
        rec_b.run_length  = run_len;
        rec_b.last_report = 1'b1;

        push.second = rec_b;
        if (emit_a)
        begin
            push.first = rec_a;
        end
        else
        begin
            push.first = rec_b;
        end

        if (!accept)
        begin
            push.count = '0;
        end
        else
        begin
            push.count = fbrf_pkg::PCNT_W'(emit_a) + fbrf_pkg::PCNT_W'(emit_b);
        end
    end

    // Next state; the end-of-stream mark returns the tracker to its reset state.
    always_comb
    begin
        if (end_of_stream)
        begin
            prior_next  = '0;
            in_run_next = 1'b0;
            start_next  = '0;
            len_next    = '0;
            addr_next   = '0;
        end
        else
        begin
            prior_next  = data_byte;
            in_run_next = run_open;
            start_next  = run_start;
            len_next    = run_len;
            addr_next   = addr_reg + 1'b1;
        end
    end

    // State registers, updated on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg  <= '0;
            in_run_reg <= 1'b0;
            start_reg  <= '0;
            len_reg    <= '0;
            addr_reg   <= '0;
        end
        else if (accept)
        begin
            prior_reg  <= prior_next;
            in_run_reg <= in_run_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
        end
    end

endmodule

>>> hw/rtl/fbrf_outq.sv
// Output queue: three report slots shifted towards the head, which drives the ports.
module fbrf_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  fbrf_pkg::push_t   push,
    input  logic              pop,
    output fbrf_pkg::result_t head,
    output logic              head_valid,
    output logic              room_for_two
);

    fbrf_pkg::result_t           slot_reg  [fbrf_pkg::Q_DEPTH];
    fbrf_pkg::result_t           slot_next [fbrf_pkg::Q_DEPTH];
    fbrf_pkg::result_t           slot_shift[fbrf_pkg::Q_DEPTH];
    logic [fbrf_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [fbrf_pkg::QCNT_W-1:0] count_shift;

    // Drop the head on a pop, then append the new reports behind what remains.
    always_comb
    begin
        for (int i = 0; i < fbrf_pkg::Q_DEPTH - 1; i++)
        begin
            slot_shift[i] = pop ? slot_reg[i + 1] : slot_reg[i];
        end
        slot_shift[fbrf_pkg::Q_DEPTH - 1] = slot_reg[fbrf_pkg::Q_DEPTH - 1];
        count_shift = count_reg - fbrf_pkg::QCNT_W'(pop);

        for (int i = 0; i < fbrf_pkg::Q_DEPTH; i++)
        begin
            slot_next[i] = slot_shift[i];
            if ((push.count != '0) && (fbrf_pkg::QCNT_W'(i) == count_shift))
            begin
                slot_next[i] = push.first;
            end
            if ((push.count == fbrf_pkg::PCNT_W'(2)) &&
                (fbrf_pkg::QCNT_W'(i) == count_shift + 1'b1))
            begin
                slot_next[i] = push.second;
            end
        end
        count_next = count_shift + fbrf_pkg::QCNT_W'(push.count);
    end

    // Occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Report payload slots.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < fbrf_pkg::Q_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign head         = slot_reg[0];
    assign head_valid   = (count_reg != '0);
    assign room_for_two = (count_reg <= fbrf_pkg::QCNT_W'(fbrf_pkg::Q_DEPTH - 2));

endmodule

>>> hw/rtl/fill_byte_run_finder_top.sv
// Top level of the fill byte run finder.
//
// The block scans a byte stream, one byte per input beat on the in_valid /
// in_stall channel, with end_of_stream marking the last byte of a stream.
// It reports each run of identical 0x00 or 0xFF bytes whose length reaches
// the configured minimum on the out_valid / out_stall channel: fill byte,
// start address and length, with last_report set on the final report raised
// by a byte. A byte may raise none, one or two reports.
// A report is registered in the output queue when the byte that closes its
// run is accepted. Throughput: one byte per cycle while the receiver keeps
// up; a byte that raises two reports needs an output beat for each and
// holds the input off until the queue has room for two reports again.
// The reports wait in a three-slot output queue; the input is stalled while
// that queue holds two or more reports, so a stalled receiver backs the input
// up and nothing is lost. The user must write the minimum run length
// through cfg_write_en / cfg_write_data only while the block is idle; the
// block does not enforce it. Reset clears the run state and queue and sets
// the minimum to 1. Addresses restart at zero after each end-of-stream mark.
module fill_byte_run_finder_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [fbrf_pkg::LEN_W-1:0]   cfg_write_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [fbrf_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         end_of_stream,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fbrf_pkg::BYTE_W-1:0]  fill_value,
    output logic [fbrf_pkg::POS_W-1:0]   run_start,
    output logic [fbrf_pkg::LEN_W-1:0]   run_length,
    output logic                         last_report
);

    logic [fbrf_pkg::LEN_W-1:0] min_run_len_reg;
    logic                       in_accept;
    logic                       out_pop;
    logic                       room_for_two;
    fbrf_pkg::push_t            push;
    fbrf_pkg::result_t          head;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_len_reg <= fbrf_pkg::MIN_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            min_run_len_reg <= cfg_write_data;
        end
    end

    // Handshakes.
    assign in_stall  = !room_for_two;
    assign in_accept = in_valid && !in_stall;
    assign out_pop   = out_valid && !out_stall;

    fbrf_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .min_run_len   (min_run_len_reg),
        .push          (push)
    );

    fbrf_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .pop          (out_pop),
        .head         (head),
        .head_valid   (out_valid),
        .room_for_two (room_for_two)
    );

    // Output payload from the queue head.
    assign fill_value  = head.fill_value;
    assign run_start   = head.run_start;
    assign run_length  = head.run_length;
    assign last_report = head.last_report;

    // Reports are only raised by an accepted beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != '0) |-> in_accept)
    else $error("report raised without an accepted input beat");

    // Two reports from one byte only happen when that byte ends the stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == fbrf_pkg::PCNT_W'(2)) |-> end_of_stream)
    else $error("two reports raised by a byte that does not end the stream");

    // On a pair of reports, exactly the final one carries the last-report mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == fbrf_pkg::PCNT_W'(2)) |->
            (!push.first.last_report && push.second.last_report))
    else $error("last-report mark misplaced on a pair of reports");

    // A delivered run is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length != '0))
    else $error("report with zero run length");

endmodule
